// ===== rtl/core/tgcl_pkg.sv =====
package tgcl_pkg;

	localparam int TABLE_DEPTH_DEFAULT = 256;

	localparam int OP_W = 2;
	localparam logic [OP_W-1:0] OP_LOAD   = 2'd0;
	localparam logic [OP_W-1:0] OP_CHAR   = 2'd1;
	localparam logic [OP_W-1:0] OP_CURSOR = 2'd2;

	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] REG_FONT_VALID   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_GLYPH_HEIGHT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_FIRST_CODE   = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_GLYPH_COUNT  = 2'd3;

	localparam logic [7:0] RESET_GLYPH_HEIGHT = 8'd8;
	localparam logic [7:0] RESET_FIRST_CODE   = 8'd32;

	localparam logic [7:0]  NEWLINE_CODE = 8'd10;
	localparam logic [15:0] HEADER_BYTES = 16'd6;
	localparam logic [7:0]  SPACER_LIMIT = 8'd128;

	localparam logic KIND_GLYPH  = 1'b0;
	localparam logic KIND_SPACER = 1'b1;

endpackage

// ===== rtl/core/text_glyph_cursor_locator_core.sv =====
// Load, set cursor, newline and ignored items are handled without leaving the idle state.
// A character at glyph index g walks the width RAM one entry per cycle through a
// single multiply-add; a finish state after the walk registers its glyph command.
// The spacer command is presented in the cycle after the glyph command is taken.
// One item is handled at a time; the input stays stalled until the last command of a character is taken.
// Asynchronous reset clears the cursor and the configuration registers to defaults; the width RAM is not cleared.
module text_glyph_cursor_locator_core #(
	parameter int TABLE_DEPTH = tgcl_pkg::TABLE_DEPTH_DEFAULT
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_write,
	input  logic [tgcl_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [7:0]                       cfg_data,
	input  logic                             in_valid,
	output logic                             in_stall,
	input  logic [tgcl_pkg::OP_W-1:0]        operation,
	input  logic [7:0]                       table_index,
	input  logic [7:0]                       width_value,
	input  logic [7:0]                       char_code,
	input  logic signed [15:0]               new_x,
	input  logic signed [15:0]               new_y,
	output logic                             out_valid,
	input  logic                             out_stall,
	output logic                             command_kind,
	output logic signed [15:0]               draw_x,
	output logic signed [15:0]               draw_y,
	output logic [7:0]                       draw_width,
	output logic [7:0]                       draw_height,
	output logic [15:0]                      bitmap_offset,
	output logic                             last
);

	localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_WALK,
		ST_FINISH,
		ST_EMIT_GLYPH,
		ST_EMIT_SPACER
	} state_t;

	state_t      state_q;
	logic        font_valid_q;
	logic [7:0]  glyph_height_q;
	logic [7:0]  first_code_q;
	logic [7:0]  glyph_count_q;
	logic [15:0] cursor_x_q;
	logic [15:0] cursor_y_q;
	logic [7:0]  idx_q;
	logic [7:0]  gi_q;
	logic [5:0]  rows_q;
	logic [15:0] off_q;
	logic        spacer_q;
	logic [7:0]  glyph_w_q;
	logic        rd_valid_s1;
	logic        rd_last_s1;
	logic        rd_inrange_s1;
	logic        out_valid_q;
	logic        kind_q;
	logic [15:0] x_q;
	logic [15:0] y_q;
	logic [7:0]  w_q;
	logic [7:0]  h_q;
	logic [15:0] ofs_q;
	logic        last_q;

	logic        in_acc;
	logic        out_acc;
	logic        in_font;
	logic        ram_we;
	logic [7:0]  rd_data;
	logic [7:0]  rd_width;
	logic [13:0] prod;
	logic [15:0] mac;
	logic [8:0]  font_end;
	logic [8:0]  rows_sum;

	assign in_stall = (state_q != ST_IDLE);
	assign in_acc = in_valid && !in_stall;
	assign out_acc = out_valid_q && !out_stall;

	assign font_end = {1'b0, first_code_q} + {1'b0, glyph_count_q};
	assign in_font = (char_code >= first_code_q) && ({1'b0, char_code} < font_end);
	assign rows_sum = {1'b0, glyph_height_q} + 9'd7;

	assign ram_we = in_acc && (operation == tgcl_pkg::OP_LOAD)
		&& ({1'b0, table_index} < 9'(TABLE_DEPTH));

	tgcl_width_ram #(
		.DEPTH(TABLE_DEPTH),
		.AW(AW)
	) u_width_ram (
		.clk(clk),
		.wr_en(ram_we),
		.wr_addr(table_index[AW-1:0]),
		.wr_data(width_value),
		.rd_addr(idx_q[AW-1:0]),
		.rd_data(rd_data)
	);

	assign rd_width = rd_inrange_s1 ? rd_data : 8'd0;
	assign prod = {6'd0, rd_width} * {8'd0, rows_q};
	assign mac = off_q + {2'd0, prod};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			font_valid_q <= 1'b0;
			glyph_height_q <= tgcl_pkg::RESET_GLYPH_HEIGHT;
			first_code_q <= tgcl_pkg::RESET_FIRST_CODE;
			glyph_count_q <= 8'd0;
			cursor_x_q <= 16'd0;
			cursor_y_q <= 16'd0;
			rd_valid_s1 <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_write) begin
				case (cfg_index)
					tgcl_pkg::REG_FONT_VALID:   font_valid_q <= cfg_data[0];
					tgcl_pkg::REG_GLYPH_HEIGHT: glyph_height_q <= cfg_data;
					tgcl_pkg::REG_FIRST_CODE:   first_code_q <= cfg_data;
					tgcl_pkg::REG_GLYPH_COUNT:  glyph_count_q <= cfg_data;
					default: ;
				endcase
			end

			rd_valid_s1 <= (state_q == ST_WALK);
			rd_last_s1 <= (idx_q == gi_q);
			rd_inrange_s1 <= ({1'b0, idx_q} < 9'(TABLE_DEPTH));

			if (rd_valid_s1 && !rd_last_s1) begin
				off_q <= mac;
			end

			case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						if (operation == tgcl_pkg::OP_CURSOR) begin
							cursor_x_q <= new_x;
							cursor_y_q <= new_y;
						end else if (operation == tgcl_pkg::OP_CHAR && font_valid_q) begin
							if (char_code == tgcl_pkg::NEWLINE_CODE) begin
								cursor_x_q <= 16'd0;
								cursor_y_q <= cursor_y_q + {8'd0, glyph_height_q};
							end else if (in_font) begin
								idx_q <= 8'd0;
								gi_q <= char_code - first_code_q;
								rows_q <= rows_sum[8:3];
								off_q <= {8'd0, glyph_count_q} + tgcl_pkg::HEADER_BYTES;
								spacer_q <= (char_code < tgcl_pkg::SPACER_LIMIT);
								state_q <= ST_WALK;
							end
						end
					end
				end
				ST_WALK: begin
					idx_q <= idx_q + 8'd1;
					if (idx_q == gi_q) begin
						state_q <= ST_FINISH;
					end
				end
				ST_FINISH: begin
					glyph_w_q <= rd_width;
					kind_q <= tgcl_pkg::KIND_GLYPH;
					x_q <= cursor_x_q;
					y_q <= cursor_y_q;
					w_q <= rd_width;
					h_q <= glyph_height_q;
					ofs_q <= off_q;
					last_q <= !spacer_q;
					out_valid_q <= 1'b1;
					state_q <= ST_EMIT_GLYPH;
				end
				ST_EMIT_GLYPH: begin
					if (out_acc) begin
						cursor_x_q <= cursor_x_q + {8'd0, glyph_w_q};
						if (spacer_q) begin
							kind_q <= tgcl_pkg::KIND_SPACER;
							x_q <= cursor_x_q + {8'd0, glyph_w_q};
							w_q <= 8'd1;
							ofs_q <= 16'd0;
							last_q <= 1'b1;
							state_q <= ST_EMIT_SPACER;
						end else begin
							out_valid_q <= 1'b0;
							state_q <= ST_IDLE;
						end
					end
				end
				ST_EMIT_SPACER: begin
					if (out_acc) begin
						cursor_x_q <= cursor_x_q + 16'd1;
						out_valid_q <= 1'b0;
						state_q <= ST_IDLE;
					end
				end
				default: begin
					out_valid_q <= 1'b0;
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign command_kind = kind_q;
	assign draw_x = x_q;
	assign draw_y = y_q;
	assign draw_width = w_q;
	assign draw_height = h_q;
	assign bitmap_offset = ofs_q;
	assign last = last_q;

endmodule

// ===== rtl/core/tgcl_width_ram.sv =====
module tgcl_width_ram #(
	parameter int DEPTH = tgcl_pkg::TABLE_DEPTH_DEFAULT,
	parameter int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic          clk,
	input  logic          wr_en,
	input  logic [AW-1:0] wr_addr,
	input  logic [7:0]    wr_data,
	input  logic [AW-1:0] rd_addr,
	output logic [7:0]    rd_data
);

	logic [7:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data <= mem[rd_addr];
	end

endmodule

// ===== rtl/core/tgcl_checker.sv =====
module tgcl_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           in_stall,
	input logic                           out_valid,
	input logic                           out_stall,
	input logic                           command_kind,
	input logic signed [15:0]             draw_x,
	input logic signed [15:0]             draw_y,
	input logic [7:0]                     draw_width,
	input logic [7:0]                     draw_height,
	input logic [15:0]                    bitmap_offset,
	input logic                           last
);

	// A stalled command must hold its place, kind, x position, bitmap offset and last flag.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(command_kind) && $stable(draw_x)
			&& $stable(bitmap_offset) && $stable(last))
		else $error("stalled command changed");

	// No new item is taken while a command is still pending.
	a_busy_while_out: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> in_stall)
		else $error("input taken while a command is pending");

	// A spacer is always one column wide, has no bitmap and closes the character.
	a_spacer_shape: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && command_kind == tgcl_pkg::KIND_SPACER |->
			last && draw_width == 8'd1 && bitmap_offset == 16'd0)
		else $error("malformed spacer command");

	// A glyph command that is not last is followed at once by its spacer.
	a_spacer_follows: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && command_kind == tgcl_pkg::KIND_GLYPH && !last |=>
			out_valid && command_kind == tgcl_pkg::KIND_SPACER
			&& draw_y == $past(draw_y) && draw_height == $past(draw_height))
		else $error("spacer did not follow its glyph");

endmodule

bind text_glyph_cursor_locator_core tgcl_checker u_tgcl_checker (.*);
